// ===== rtl/core/murm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murm_pkg
// Shared types, constants and helpers for the streaming MurmurHash2 block.
// ----------------------------------------------------------------------------
package murm_pkg;

    // Mixing constants of the 32-bit MurmurHash2
    localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
    localparam int          MIX_SHIFT = 24;
    localparam int          FIN_SH1   = 13;
    localparam int          FIN_SH2   = 15;

    // A full word carries four bytes
    localparam logic [2:0]  CNT_FULL  = 3'd4;

    // One input word as handed from the port side to the core
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        first_word;
        logic        last_word;
        logic [31:0] seed;
        logic [31:0] message_length;
    } t_item;

    // One finished hash
    typedef struct packed {
        logic [31:0] hash_value;
        logic        length_mismatch;
    } t_result;

    // Counts of five to seven mean a full word
    function automatic logic [2:0] clamp_count(input logic [2:0] cnt);
        logic [2:0] res;
        res = (cnt > CNT_FULL) ? CNT_FULL : cnt;
        return res;
    endfunction

    // Keep the low tail bytes of a short last word
    function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
        logic [31:0] res;
        unique case (cnt)
            3'd1:    res = 32'h0000_00ff;
            3'd2:    res = 32'h0000_ffff;
            3'd3:    res = 32'h00ff_ffff;
            default: res = 32'hffff_ffff;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/murm_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murm_mul
// Shared multiplier by the mixing constant; low 32 bits, registered result,
// updated only when enabled so the product can be held for later states.
// ----------------------------------------------------------------------------
module murm_mul import murm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_operand,
    output logic      [31:0] o_product
);

    logic [31:0] r_prod;
    logic [31:0] n_prod;

    // Product modulo 2^32
    assign n_prod = i_operand * MIX_MUL;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_product = r_prod;

endmodule
`default_nettype wire

// ===== rtl/core/murm_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murm_core
// Sequencer and hash state. Every multiplication of a word (key mix, key
// remix, accumulator, tail, avalanche) goes through one shared multiplier.
// ----------------------------------------------------------------------------
module murm_core import murm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_item   i_item,
    output logic         o_idle,
    output logic         o_res_valid,
    input  wire logic    i_res_take,
    output t_result      o_result
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_K1   = 4'd1;
    localparam logic [3:0] ST_K2   = 4'd2;
    localparam logic [3:0] ST_HM   = 4'd3;
    localparam logic [3:0] ST_MIX  = 4'd4;
    localparam logic [3:0] ST_TAIL = 4'd5;
    localparam logic [3:0] ST_TLW  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]  r_state, n_state;
    logic [31:0] r_h, n_h;
    logic [31:0] r_seen, n_seen;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic [31:0] r_k, n_k;

    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [2:0]  cnt_in;

    murm_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (mul_en),
        .i_operand (mul_a),
        .o_product (prod)
    );

    assign cnt_in = clamp_count(i_item.byte_count);

    // Next-state and operand selection
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_seen  = r_seen;
        n_decl  = r_decl;
        n_word  = r_word;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_k     = r_k;
        mul_en  = 1'b0;
        mul_a   = r_h;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_word = i_item.data_word;
                    n_cnt  = cnt_in;
                    n_last = i_item.last_word;
                    if (i_item.first_word) begin
                        n_h    = i_item.seed ^ i_item.message_length;
                        n_seen = '0;
                        n_decl = i_item.message_length;
                    end
                    // short words that are not last are dropped
                    if (cnt_in == CNT_FULL) begin
                        n_state = ST_K1;
                    end else if (!i_item.last_word) begin
                        n_state = ST_IDLE;
                    end else if (cnt_in != 3'd0) begin
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_K1: begin
                mul_en  = 1'b1;
                mul_a   = r_word;
                n_state = ST_K2;
            end
            ST_K2: begin
                mul_en  = 1'b1;
                mul_a   = prod ^ (prod >> MIX_SHIFT);
                n_state = ST_HM;
            end
            ST_HM: begin
                mul_en  = 1'b1;
                mul_a   = r_h;
                n_k     = prod;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                n_h     = prod ^ r_k;
                n_seen  = r_seen + 32'd4;
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_TAIL: begin
                mul_en  = 1'b1;
                mul_a   = r_h ^ (r_word & tail_mask(r_cnt));
                n_state = ST_TLW;
            end
            ST_TLW: begin
                n_h     = prod;
                n_seen  = r_seen + {29'd0, r_cnt};
                n_state = ST_FIN;
            end
            ST_FIN: begin
                mul_en  = 1'b1;
                mul_a   = r_h ^ (r_h >> FIN_SH1);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // product is held until the result is taken
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h     <= '0;
            r_seen  <= '0;
            r_decl  <= '0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_seen  <= n_seen;
            r_decl  <= n_decl;
        end
    end

    // Word payload
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_k    <= n_k;
    end

    assign o_idle                   = (r_state == ST_IDLE);
    assign o_res_valid              = (r_state == ST_OUT);
    assign o_result.hash_value      = prod ^ (prod >> FIN_SH2);
    assign o_result.length_mismatch = (r_seen != r_decl);

endmodule
`default_nettype wire

// ===== rtl/core/murmur2_hash_stream.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_hash_stream
// Streaming 32-bit MurmurHash2 with byte-count check against declared length.
// ----------------------------------------------------------------------------
// Words are taken one at a time; o_in_stall is high while a word is in work.
// All multiplications run through a single registered 32-bit multiplier, so
// work per word grows with its multiplies: a short word that is not last is
// dropped, a full word runs key mix, key remix and accumulator multiplies,
// a full last word adds the avalanche, a last word with 1 to 3 tail bytes
// runs tail and avalanche multiplies, an empty last word the avalanche only.
// The hash sits in an output register, so a new message can start while it
// waits; the core holds in its final step only if that register is full.
// Hash state persists across messages until a word with first_word set.
// ----------------------------------------------------------------------------
module murmur2_hash_stream import murm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_first_word,
    input  wire logic        i_last_word,
    input  wire logic [31:0] i_seed,
    input  wire logic [31:0] i_message_length,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_hash_value,
    output logic             o_length_mismatch
);

    t_item       item;
    t_result     core_res;
    logic        core_idle;
    logic        core_res_valid;
    logic        out_free;
    logic        in_xfer;
    logic        r_out_valid;
    logic [31:0] r_hash;
    logic        r_mismatch;

    assign item.data_word      = i_data_word;
    assign item.byte_count     = i_byte_count;
    assign item.first_word     = i_first_word;
    assign item.last_word      = i_last_word;
    assign item.seed           = i_seed;
    assign item.message_length = i_message_length;

    assign o_in_stall = !core_idle;
    assign in_xfer    = i_in_valid && core_idle;
    assign out_free   = !r_out_valid || !i_out_stall;

    murm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_xfer),
        .i_item      (item),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_take  (out_free),
        .o_result    (core_res)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= core_res_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_free && core_res_valid) begin
            r_hash     <= core_res.hash_value;
            r_mismatch <= core_res.length_mismatch;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_hash;
    assign o_length_mismatch = r_mismatch;

endmodule
`default_nettype wire

// ===== rtl/core/murm_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murm_chk
// Port-level checks for the streaming MurmurHash2 block, bound to the top.
// ----------------------------------------------------------------------------
module murm_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_hash_value,
    input  wire logic        i_length_mismatch
);

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=>
            (i_out_valid && $stable(i_hash_value) && $stable(i_length_mismatch)))
        else $error("stalled result changed");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A new result is preceded by a busy sequencer in its avalanche and output steps
    a_busy_before_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> ($past(i_in_stall, 1) && $past(i_in_stall, 2)))
        else $error("result without busy sequencer");

    // A transfer on the input always takes the sequencer out of idle,
    // unless the word was a dropped short word; either way no result
    // may appear in the very next cycle
    a_no_instant_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall && !i_out_valid) |=> !i_out_valid)
        else $error("result one cycle after transfer");

endmodule

bind murmur2_hash_stream murm_chk u_murm_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .i_in_stall        (o_in_stall),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_hash_value      (o_hash_value),
    .i_length_mismatch (o_length_mismatch)
);
`default_nettype wire
